>>> rtl/tet_radius_ratio_quality_defines.svh
// Assertion macros used by the tetrahedron quality checker.
`ifndef TET_RADIUS_RATIO_QUALITY_DEFINES_SVH
`define TET_RADIUS_RATIO_QUALITY_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define TRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define TRQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> rtl/trq_pkg.sv
// Shared constants and tables for the tetrahedron quality pipeline.
`timescale 1ns / 1ps
`default_nettype none
package trq_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned QUALITY_FRAC_BITS_DEF = 16;

  // Quality output format
  localparam int unsigned QUALITY_W = 16;
  localparam logic [QUALITY_W-1:0] QUALITY_MAX = '1;

  // Pipelined multiplier: operand chunk width and stage count
  localparam int unsigned MUL_CHUNK = 32;
  localparam int unsigned MUL_LAT = 5;

  // Divider: one saturation stage plus one stage per quotient bit
  localparam int unsigned DIV_LAT = QUALITY_W + 1;

  // Edge i runs from vertex EDGE_B[i] to vertex EDGE_A[i]
  localparam int unsigned EDGE_A [6] = '{0, 1, 2, 0, 1, 2};
  localparam int unsigned EDGE_B [6] = '{1, 2, 0, 3, 3, 3};

  // Cross products: four faces, then the one used by the triple product
  localparam int unsigned NUM_CROSS = 5;
  localparam int unsigned NUM_FACES = 4;
  localparam int unsigned CROSS_A [NUM_CROSS] = '{0, 0, 4, 2, 0};
  localparam int unsigned CROSS_B [NUM_CROSS] = '{1, 4, 1, 5, 2};
  localparam int unsigned TRI_EDGE = 3;

endpackage
`default_nettype wire

>>> rtl/tet_radius_ratio_quality.sv
// Throughput: one item per cycle; busy stays low, so start may be held every cycle.
// The longest sections are the 67-stage face-norm square root and the 17-stage divider.
// Results appear on done_o for one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the valid pipe; items in flight are dropped.
// Top level: tetrahedron inradius over longest edge quality pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tet_radius_ratio_quality #(
  parameter int unsigned COORD_BITS        = trq_pkg::COORD_BITS_DEF,
  parameter int unsigned QUALITY_FRAC_BITS = trq_pkg::QUALITY_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [COORD_BITS-1:0]         x0_i,
  input  wire logic signed [COORD_BITS-1:0]         y0_i,
  input  wire logic signed [COORD_BITS-1:0]         z0_i,
  input  wire logic signed [COORD_BITS-1:0]         x1_i,
  input  wire logic signed [COORD_BITS-1:0]         y1_i,
  input  wire logic signed [COORD_BITS-1:0]         z1_i,
  input  wire logic signed [COORD_BITS-1:0]         x2_i,
  input  wire logic signed [COORD_BITS-1:0]         y2_i,
  input  wire logic signed [COORD_BITS-1:0]         z2_i,
  input  wire logic signed [COORD_BITS-1:0]         x3_i,
  input  wire logic signed [COORD_BITS-1:0]         y3_i,
  input  wire logic signed [COORD_BITS-1:0]         z3_i,
  output logic                                      done_o,
  output logic             [trq_pkg::QUALITY_W-1:0] quality_o,
  output logic                                      degenerate_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned EW   = CB + 1;        // edge component
  localparam int unsigned PW   = 2 * EW;        // edge product / squared length
  localparam int unsigned CW   = PW + 1;        // cross product component
  localparam int unsigned N2W  = 2 * CW;        // squared face norm
  localparam int unsigned CSW  = CW + 2;        // sum of four face norms
  localparam int unsigned TPW  = EW + CW;       // triple product term
  localparam int unsigned TW   = TPW + 2;       // triple product
  localparam int unsigned DPW  = CSW + EW + 2;  // signed C*H product
  localparam int unsigned DW   = CSW + EW;      // C*H
  localparam int unsigned M    = trq_pkg::MUL_LAT;
  localparam int unsigned T_C  = 4 + 2 * M + CW;
  localparam int unsigned D_E3 = 1 + M;
  localparam int unsigned D_H  = M + CW - EW;
  localparam int unsigned D_T  = CW + M;
  localparam int unsigned D_DG = M + trq_pkg::DIV_LAT;
  localparam int unsigned LAT  = T_C + M + trq_pkg::DIV_LAT + 1;
  localparam int unsigned NC   = trq_pkg::NUM_CROSS;
  localparam int unsigned NF   = trq_pkg::NUM_FACES;

  logic [EW-1:0]  v      [4][3];
  logic [EW-1:0]  e_q    [6][3];
  logic [PW-1:0]  esq    [6][3];
  logic [PW-1:0]  l2_q   [6];
  logic [PW-1:0]  m3_q   [3];
  logic [PW-1:0]  mx_q;
  logic [EW-1:0]  h;
  logic [EW-1:0]  hd;
  logic [PW-1:0]  xp     [NC][3][2];
  logic [CW-1:0]  cr_q   [NC][3];
  logic [N2W-1:0] nsq    [NF][3];
  logic [N2W-1:0] n2_q   [NF];
  logic [CW-1:0]  fn     [NF];
  logic [CSW-1:0] c_q;
  logic [3*EW-1:0] e3_pk;
  logic [3*EW-1:0] e3d_pk;
  logic [TPW-1:0] tp     [3];
  logic [TW-1:0]  t_q;
  logic [TW-1:0]  tabs_q;
  logic [TW-1:0]  tabs_d;
  logic [DPW-1:0] den_p;
  logic           dg;
  logic           dgd;
  logic [trq_pkg::QUALITY_W-1:0] quot;
  logic           sat;
  logic [LAT-1:0] valid_q;
  logic [trq_pkg::QUALITY_W-1:0] quality_q;
  logic           degenerate_q;

  // never stalls
  assign busy = 1'b0;

  // valid bits follow the items through the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], start & ~busy};
    end
  end

  // sign-extended vertices
  assign v[0][0] = {x0_i[CB-1], x0_i};
  assign v[0][1] = {y0_i[CB-1], y0_i};
  assign v[0][2] = {z0_i[CB-1], z0_i};
  assign v[1][0] = {x1_i[CB-1], x1_i};
  assign v[1][1] = {y1_i[CB-1], y1_i};
  assign v[1][2] = {z1_i[CB-1], z1_i};
  assign v[2][0] = {x2_i[CB-1], x2_i};
  assign v[2][1] = {y2_i[CB-1], y2_i};
  assign v[2][2] = {z2_i[CB-1], z2_i};
  assign v[3][0] = {x3_i[CB-1], x3_i};
  assign v[3][1] = {y3_i[CB-1], y3_i};
  assign v[3][2] = {z3_i[CB-1], z3_i};

  // edge vectors for all vertex pairs
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        e_q[i][k] <= v[trq_pkg::EDGE_A[i]][k] - v[trq_pkg::EDGE_B[i]][k];
      end
    end
  end

  // squared edge lengths
  for (genvar i = 0; i < 6; i++) begin : g_esq
    for (genvar k = 0; k < 3; k++) begin : g_comp
      trq_smul #(.AW(EW), .BW(EW)) u_mul (
        .clk_i (clk_i),
        .a_i   (e_q[i][k]),
        .b_i   (e_q[i][k]),
        .p_o   (esq[i][k])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      l2_q[i] <= esq[i][0] + esq[i][1] + esq[i][2];
    end
  end

  // longest edge: pairwise max, then max of three
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      m3_q[j] <= (l2_q[2*j+1] > l2_q[2*j]) ? l2_q[2*j+1] : l2_q[2*j];
    end
    if (m3_q[1] > m3_q[0]) begin
      mx_q <= (m3_q[2] > m3_q[1]) ? m3_q[2] : m3_q[1];
    end else begin
      mx_q <= (m3_q[2] > m3_q[0]) ? m3_q[2] : m3_q[0];
    end
  end

  trq_isqrt #(.IW(PW)) u_hsqrt (
    .clk_i  (clk_i),
    .n_i    (mx_q),
    .root_o (h)
  );

  trq_delay #(.W(EW), .D(D_H)) u_hdly (
    .clk_i (clk_i),
    .d_i   (h),
    .q_o   (hd)
  );

  // cross products: four faces and e0 x e2
  for (genvar f = 0; f < NC; f++) begin : g_cross
    for (genvar c = 0; c < 3; c++) begin : g_comp
      trq_smul #(.AW(EW), .BW(EW)) u_mul_p (
        .clk_i (clk_i),
        .a_i   (e_q[trq_pkg::CROSS_A[f]][(c+1)%3]),
        .b_i   (e_q[trq_pkg::CROSS_B[f]][(c+2)%3]),
        .p_o   (xp[f][c][0])
      );
      trq_smul #(.AW(EW), .BW(EW)) u_mul_n (
        .clk_i (clk_i),
        .a_i   (e_q[trq_pkg::CROSS_A[f]][(c+2)%3]),
        .b_i   (e_q[trq_pkg::CROSS_B[f]][(c+1)%3]),
        .p_o   (xp[f][c][1])
      );

      always_ff @(posedge clk_i) begin
        cr_q[f][c] <= {xp[f][c][0][PW-1], xp[f][c][0]} - {xp[f][c][1][PW-1], xp[f][c][1]};
      end
    end
  end

  // face norms
  for (genvar f = 0; f < NF; f++) begin : g_face
    for (genvar c = 0; c < 3; c++) begin : g_comp
      trq_smul #(.AW(CW), .BW(CW)) u_mul (
        .clk_i (clk_i),
        .a_i   (cr_q[f][c]),
        .b_i   (cr_q[f][c]),
        .p_o   (nsq[f][c])
      );
    end

    always_ff @(posedge clk_i) begin
      n2_q[f] <= nsq[f][0] + nsq[f][1] + nsq[f][2];
    end

    trq_isqrt #(.IW(N2W)) u_fsqrt (
      .clk_i  (clk_i),
      .n_i    (n2_q[f]),
      .root_o (fn[f])
    );
  end

  // total of the four face norms
  always_ff @(posedge clk_i) begin
    c_q <= CSW'(fn[0]) + CSW'(fn[1]) + CSW'(fn[2]) + CSW'(fn[3]);
  end

  // triple product e3 . (e0 x e2)
  assign e3_pk = {e_q[trq_pkg::TRI_EDGE][2], e_q[trq_pkg::TRI_EDGE][1],
                  e_q[trq_pkg::TRI_EDGE][0]};

  trq_delay #(.W(3*EW), .D(D_E3)) u_e3dly (
    .clk_i (clk_i),
    .d_i   (e3_pk),
    .q_o   (e3d_pk)
  );

  for (genvar k = 0; k < 3; k++) begin : g_tri
    trq_smul #(.AW(EW), .BW(CW)) u_mul (
      .clk_i (clk_i),
      .a_i   (e3d_pk[EW*k +: EW]),
      .b_i   (cr_q[NC-1][k]),
      .p_o   (tp[k])
    );
  end

  always_ff @(posedge clk_i) begin
    t_q    <= {{2{tp[0][TPW-1]}}, tp[0]} + {{2{tp[1][TPW-1]}}, tp[1]}
            + {{2{tp[2][TPW-1]}}, tp[2]};
    tabs_q <= t_q[TW-1] ? (~t_q + TW'(1)) : t_q;
  end

  trq_delay #(.W(TW), .D(D_T)) u_tdly (
    .clk_i (clk_i),
    .d_i   (tabs_q),
    .q_o   (tabs_d)
  );

  // denominator C * H
  trq_smul #(.AW(CSW+1), .BW(EW+1)) u_den (
    .clk_i (clk_i),
    .a_i   ({1'b0, c_q}),
    .b_i   ({1'b0, hd}),
    .p_o   (den_p)
  );

  trq_div #(.TW(TW), .DW(DW), .FRAC(QUALITY_FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .tabs_i (tabs_d),
    .den_i  (den_p[DW-1:0]),
    .quot_o (quot),
    .sat_o  (sat)
  );

  // zero area or zero edge
  assign dg = (c_q == '0) || (hd == '0);

  trq_delay #(.W(1), .D(D_DG)) u_dgdly (
    .clk_i (clk_i),
    .d_i   (dg),
    .q_o   (dgd)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (dgd) begin
      quality_q <= '0;
    end else if (sat) begin
      quality_q <= trq_pkg::QUALITY_MAX;
    end else begin
      quality_q <= quot;
    end
    degenerate_q <= dgd;
  end

  assign done_o       = valid_q[LAT-1];
  assign quality_o    = quality_q;
  assign degenerate_o = degenerate_q;

endmodule
`default_nettype wire

>>> rtl/trq_delay.sv
// Fixed-depth delay line used to keep side values aligned with the datapath.
`timescale 1ns / 1ps
`default_nettype none
module trq_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 1
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  // shift one stage per cycle
  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < int'(D); k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[D-1];

endmodule
`default_nettype wire

>>> rtl/trq_smul.sv
// Pipelined signed multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module trq_smul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  wire logic               clk_i,
  input  wire logic [AW-1:0]      a_i,
  input  wire logic [BW-1:0]      b_i,
  output logic      [AW+BW-1:0]   p_o
);

  localparam int unsigned CH = trq_pkg::MUL_CHUNK;
  localparam int unsigned NA = (AW + CH - 1) / CH;
  localparam int unsigned NB = (BW + CH - 1) / CH;
  localparam int unsigned SW = (NA + NB) * CH;
  localparam int unsigned PW = AW + BW;

  logic [AW-1:0]     a_mag_q;
  logic [BW-1:0]     b_mag_q;
  logic [3:0]        neg_q;
  logic [NA*CH-1:0]  a_ext;
  logic [NB*CH-1:0]  b_ext;
  logic [2*CH-1:0]   pp_q  [NA][NB];
  logic [SW-1:0]     row_d [NA];
  logic [SW-1:0]     row_q [NA];
  logic [SW-1:0]     sum_d;
  logic [SW-1:0]     sum_q;
  logic [PW-1:0]     p_q;

  // stage 1: magnitudes, sign of the product travels alongside
  always_ff @(posedge clk_i) begin
    a_mag_q <= a_i[AW-1] ? (~a_i + AW'(1)) : a_i;
    b_mag_q <= b_i[BW-1] ? (~b_i + BW'(1)) : b_i;
    neg_q   <= {neg_q[2:0], a_i[AW-1] ^ b_i[BW-1]};
  end

  assign a_ext = (NA*CH)'(a_mag_q);
  assign b_ext = (NB*CH)'(b_mag_q);

  // stage 2: chunk partial products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(NA); i++) begin
      for (int j = 0; j < int'(NB); j++) begin
        pp_q[i][j] <= a_ext[CH*i +: CH] * b_ext[CH*j +: CH];
      end
    end
  end

  // stage 3: one row per chunk of a
  always_comb begin
    for (int i = 0; i < int'(NA); i++) begin
      row_d[i] = '0;
      for (int j = 0; j < int'(NB); j++) begin
        row_d[i] = row_d[i] + (SW'(pp_q[i][j]) << (CH * j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  // stage 4: sum of rows
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < int'(NA); i++) begin
      sum_d = sum_d + (row_q[i] << (CH * i));
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // stage 5: restore sign
  always_ff @(posedge clk_i) begin
    p_q <= PW'(neg_q[3] ? (~sum_q + SW'(1)) : sum_q);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> rtl/trq_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module trq_isqrt #(
  parameter int unsigned IW = 66
) (
  input  wire logic            clk_i,
  input  wire logic [IW-1:0]   n_i,
  output logic      [IW/2-1:0] root_o
);

  localparam int unsigned OW = IW / 2;
  localparam int unsigned RW = OW + 3;

  logic [RW-1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [IW-1:0] n_q    [OW];

  for (genvar s = 0; s < OW; s++) begin : g_st
    logic [RW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [IW-1:0] n_in;
    logic [RW-1:0] remx;
    logic [RW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign n_in    = n_q[s-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      remx  = {rem_in[RW-3:0], n_in[IW-1:IW-2]};
      trial = RW'({root_in, 2'b01});
      ge    = (remx >= trial);
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (remx - trial) : remx;
      root_q[s] <= {root_in[OW-2:0], ge};
      n_q[s]    <= n_in << 2;
    end
  end

  assign root_o = root_q[OW-1];

endmodule
`default_nettype wire

>>> rtl/trq_div.sv
// Pipelined restoring divider: saturated Q0.16 quotient of |T| over C*H.
`timescale 1ns / 1ps
`default_nettype none
module trq_div #(
  parameter int unsigned TW   = 168,
  parameter int unsigned DW   = 102,
  parameter int unsigned FRAC = 16
) (
  input  wire logic                            clk_i,
  input  wire logic [TW-1:0]                   tabs_i,
  input  wire logic [DW-1:0]                   den_i,
  output logic      [trq_pkg::QUALITY_W-1:0]   quot_o,
  output logic                                 sat_o
);

  localparam int unsigned QW   = trq_pkg::QUALITY_W;
  localparam int unsigned NUMW = TW + FRAC;
  localparam int unsigned HIW  = NUMW - QW;
  localparam int unsigned CMPW = (HIW > DW) ? HIW : DW;

  logic [NUMW-1:0] num;
  logic [HIW-1:0]  hi;
  logic            sat_d;

  logic [DW-1:0]   rem_q [QW+1];
  logic [DW-1:0]   den_q [QW+1];
  logic [QW-1:0]   lo_q  [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic            sat_q [QW+1];

  // dividend is |T| scaled by the fraction bits
  assign num   = {tabs_i, {FRAC{1'b0}}};
  assign hi    = num[NUMW-1:QW];
  assign sat_d = (CMPW'(hi) >= CMPW'(den_i));

  // stage 0: quotient overflow check, partial remainder from the upper part
  always_ff @(posedge clk_i) begin
    rem_q[0] <= sat_d ? '0 : DW'(hi);
    den_q[0] <= den_i;
    lo_q[0]  <= num[QW-1:0];
    quo_q[0] <= '0;
    sat_q[0] <= sat_d;
  end

  for (genvar s = 1; s <= QW; s++) begin : g_st
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_q[s-1], lo_q[s-1][QW-s]};
      ge    = (trial >= {1'b0, den_q[s-1]});
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DW'(trial - {1'b0, den_q[s-1]}) : DW'(trial);
      den_q[s] <= den_q[s-1];
      lo_q[s]  <= lo_q[s-1];
      quo_q[s] <= {quo_q[s-1][QW-2:0], ge};
      sat_q[s] <= sat_q[s-1];
    end
  end

  assign quot_o = quo_q[QW];
  assign sat_o  = sat_q[QW];

endmodule
`default_nettype wire

>>> rtl/trq_sva.sv
// Port-level checker for the tetrahedron quality pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "tet_radius_ratio_quality_defines.svh"
module trq_sva #(
  parameter int unsigned LAT = 104
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic [trq_pkg::QUALITY_W-1:0] quality_o,
  input wire logic                          degenerate_o
);

  // every accepted item comes out after the fixed latency
  `TRQ_ASSERT(a_done_after_lat, start && !busy |-> ##LAT done_o, "item result missing")
  // no result without an item accepted at the matching time
  `TRQ_ASSERT(a_done_has_item, done_o |-> $past(start && !busy, LAT), "spurious result")
  // degenerate elements report zero quality
  `TRQ_ASSERT(a_degen_zero, done_o && degenerate_o |-> quality_o == '0, "degenerate nonzero")
  // pipeline always takes a new item
  `TRQ_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind tet_radius_ratio_quality trq_sva #(.LAT(LAT)) u_trq_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .quality_o    (quality_o),
  .degenerate_o (degenerate_o)
);
`default_nettype wire
